// File: hdl/timestamp_stream_desync_finder_unit_assert.svh
// ----------------------------------------------------------------------------
// timestamp stream desync finder assertion macros
// concurrent checks that vanish when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef TIMESTAMP_STREAM_DESYNC_FINDER_UNIT_ASSERT_SVH
`define TIMESTAMP_STREAM_DESYNC_FINDER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define TSDF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tsdf check failed: same-cycle implication");
// next-cycle implication
`define TSDF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tsdf check failed: next-cycle implication");
`else
`define TSDF_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define TSDF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: hdl/tsdf_pkg.sv
// ----------------------------------------------------------------------------
// tsdf_pkg
// shared types and constants of the timestamp stream desync finder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tsdf_pkg;

  localparam int TS_W      = 64;
  localparam int CFG_W     = 32;
  localparam int CFG_AW    = 4;
  localparam int REL_W     = 16;
  localparam int STAT_W    = 3;
  localparam int CNT_OUT_W = 5;
  localparam int IDX_OUT_W = 4;
  localparam int PROD_W    = 96;
  localparam int DIV_CNT_W = 7;
  localparam int REL_STEPS = 15;

  typedef logic [1:0]        op_t;
  typedef logic [STAT_W-1:0] status_t;
  typedef logic [1:0]        reg_idx_t;

  localparam op_t OP_PUSH  = 2'd0;
  localparam op_t OP_CLEAR = 2'd1;
  localparam op_t OP_FIND  = 2'd2;

  localparam status_t STAT_DONE      = 3'd0;
  localparam status_t STAT_IN_SYNC   = 3'd1;
  localparam status_t STAT_OFFSET    = 3'd2;
  localparam status_t STAT_NONE      = 3'd3;
  localparam status_t STAT_NOT_FULL  = 3'd4;
  localparam status_t STAT_TOO_SMALL = 3'd5;

  localparam reg_idx_t REG_WINDOW = 2'd0;
  localparam reg_idx_t REG_RATIO  = 2'd1;
  localparam reg_idx_t REG_THRESH = 2'd2;

  localparam logic [CFG_W-1:0] WINDOW_RST = 32'd1;
  localparam logic [CFG_W-1:0] RATIO_RST  = 32'd65536;
  localparam logic [CFG_W-1:0] THRESH_RST = 32'd6554;
  localparam logic [CFG_W-1:0] REF_MULT   = 32'd65536;
  localparam logic [REL_W-1:0] REL_EQUAL  = 16'd32768;

  typedef struct packed {
    logic             start;
    logic [TS_W-1:0]  num;
    logic [CFG_W-1:0] mult;
    logic [CFG_W-1:0] den;
  } sdiv_req_t;

endpackage

// File: hdl/tsdf_in_if.sv
// ----------------------------------------------------------------------------
// tsdf_in_if
// input channel: operation and timestamp pair
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tsdf_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                operation;
  logic [tsdf_pkg::TS_W-1:0] ref_timestamp;
  logic [tsdf_pkg::TS_W-1:0] dut_timestamp;

  modport source (output valid, operation, ref_timestamp, dut_timestamp, input ready);
  modport sink   (input valid, operation, ref_timestamp, dut_timestamp, output ready);
endinterface

// File: hdl/tsdf_out_if.sv
// ----------------------------------------------------------------------------
// tsdf_out_if
// result channel: status and ring observations
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tsdf_out_if;
  logic                           valid;
  logic                           ready;
  logic [tsdf_pkg::STAT_W-1:0]    status;
  logic [tsdf_pkg::CNT_OUT_W-1:0] over_count;
  logic                           ring_full;
  logic [tsdf_pkg::REL_W-1:0]     target_rel_diff;
  logic [tsdf_pkg::IDX_OUT_W-1:0] desync_distance;
  logic [tsdf_pkg::IDX_OUT_W-1:0] ref_shift;
  logic [tsdf_pkg::IDX_OUT_W-1:0] dut_shift;

  modport source (output valid, status, over_count, ring_full, target_rel_diff,
                  desync_distance, ref_shift, dut_shift, input ready);
  modport sink   (input valid, status, over_count, ring_full, target_rel_diff,
                  desync_distance, ref_shift, dut_shift, output ready);
endinterface

// File: hdl/tsdf_scale_div.sv
// ----------------------------------------------------------------------------
// tsdf_scale_div
// floor(num * mult / den) saturated to the frame width, radix-2 iterative
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsdf_scale_div #(
  parameter int FRAME_WIDTH = 48
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tsdf_pkg::sdiv_req_t    req,
  output logic                   done,
  output logic [FRAME_WIDTH-1:0] quot
);
  import tsdf_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL0 = 2'd1;
  localparam logic [1:0] PH_MUL1 = 2'd2;
  localparam logic [1:0] PH_DIV  = 2'd3;

  logic [1:0]           ph_r, ph_nxt;
  logic                 add_r, add_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [TS_W-1:0]      num_r, num_nxt;
  logic [CFG_W-1:0]     mult_r, mult_nxt;
  logic [CFG_W-1:0]     den_r, den_nxt;
  logic [63:0]          p0_r, p0_nxt;
  logic [63:0]          p1_r, p1_nxt;
  logic [PROD_W-1:0]    dvd_r, dvd_nxt;
  logic [CFG_W-1:0]     rem_r, rem_nxt;

  logic [31:0] mul_a;
  logic [63:0] mul_p;
  logic [CFG_W:0] trial;

  // one shared 32x32 multiplier, low half first
  assign mul_a = (ph_r == PH_MUL0) ? num_r[31:0] : num_r[63:32];
  assign mul_p = mul_a * mult_r;
  assign trial = {rem_r, dvd_r[PROD_W-1]};

  always_comb begin
    ph_nxt   = ph_r;
    add_nxt  = 1'b0;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    mult_nxt = mult_r;
    den_nxt  = den_r;
    p0_nxt   = p0_r;
    p1_nxt   = p1_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    case (ph_r)
      PH_IDLE: begin
        if (req.start) begin
          num_nxt  = req.num;
          mult_nxt = req.mult;
          den_nxt  = req.den;
          ph_nxt   = PH_MUL0;
        end
      end
      PH_MUL0: begin
        p0_nxt = mul_p;
        ph_nxt = PH_MUL1;
      end
      PH_MUL1: begin
        p1_nxt  = mul_p;
        add_nxt = 1'b1;
        ph_nxt  = PH_DIV;
      end
      PH_DIV: begin
        if (add_r) begin
          dvd_nxt = {p1_r, 32'd0} + {32'd0, p0_r};
          rem_nxt = '0;
          cnt_nxt = DIV_CNT_W'(PROD_W - 1);
        end else begin
          // restoring step, quotient bits shift in behind the dividend
          if (trial >= {1'b0, den_r}) begin
            rem_nxt = CFG_W'(trial - {1'b0, den_r});
            dvd_nxt = {dvd_r[PROD_W-2:0], 1'b1};
          end else begin
            rem_nxt = trial[CFG_W-1:0];
            dvd_nxt = {dvd_r[PROD_W-2:0], 1'b0};
          end
          if (cnt_r == '0) begin
            done_nxt = 1'b1;
            ph_nxt   = PH_IDLE;
          end else begin
            cnt_nxt = cnt_r - 1'b1;
          end
        end
      end
      default: ph_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_IDLE;
      add_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      add_r  <= add_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    num_r  <= num_nxt;
    mult_r <= mult_nxt;
    den_r  <= den_nxt;
    p0_r   <= p0_nxt;
    p1_r   <= p1_nxt;
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
  end

  assign done = done_r;
  assign quot = (|dvd_r[PROD_W-1:FRAME_WIDTH]) ? '1 : dvd_r[FRAME_WIDTH-1:0];

endmodule

// File: hdl/tsdf_rel_div.sv
// ----------------------------------------------------------------------------
// tsdf_rel_div
// relative difference floor(|a-b| * 2^15 / (a+b)), one bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsdf_rel_div #(
  parameter int FRAME_WIDTH = 48
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [FRAME_WIDTH-1:0]       a,
  input  logic [FRAME_WIDTH-1:0]       b,
  output logic                         done,
  output logic [tsdf_pkg::REL_W-1:0]   quot
);
  import tsdf_pkg::*;

  localparam int SUM_W = FRAME_WIDTH + 1;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  logic [SUM_W-1:0] s_r, s_nxt;
  logic [SUM_W-1:0] r_r, r_nxt;
  logic [REL_W-1:0] q_r, q_nxt;

  logic                   halve;
  logic [FRAME_WIDTH-1:0] aa, bb, d;
  logic [SUM_W-1:0]       s;
  logic [SUM_W:0]         r2;

  // very wide frame values are halved before the sum
  assign halve = (FRAME_WIDTH == 64) && (a[FRAME_WIDTH-1] || b[FRAME_WIDTH-1]);
  assign aa    = halve ? (a >> 1) : a;
  assign bb    = halve ? (b >> 1) : b;
  assign s     = {1'b0, aa} + {1'b0, bb};
  assign d     = (aa > bb) ? (aa - bb) : (bb - aa);
  assign r2    = {r_r, 1'b0};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    s_nxt    = s_r;
    r_nxt    = r_r;
    q_nxt    = q_r;
    if (start) begin
      q_nxt = '0;
      if (s == '0) begin
        done_nxt = 1'b1;
      end else if ({1'b0, d} == s) begin
        q_nxt    = REL_EQUAL;
        done_nxt = 1'b1;
      end else begin
        s_nxt    = s;
        r_nxt    = {1'b0, d};
        cnt_nxt  = 4'(REL_STEPS);
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      if (r2 >= {1'b0, s_r}) begin
        r_nxt = SUM_W'(r2 - {1'b0, s_r});
        q_nxt = {q_r[REL_W-2:0], 1'b1};
      end else begin
        r_nxt = r2[SUM_W-1:0];
        q_nxt = {q_r[REL_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == 4'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    s_r   <= s_nxt;
    r_r   <= r_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// File: hdl/timestamp_stream_desync_finder_unit.sv
// ----------------------------------------------------------------------------
// timestamp_stream_desync_finder_unit
// frame-difference ring with over-threshold count and a desync/shift search
// push: setup states S_P_PREP, S_P_RD and S_P_OLD, two divides of 96 steps
//   each, the 15-step relative divide, then report states S_TGT_RD, S_TGT_WT
//   and S_DONE; clear and unknown operations go straight to the report states
// find: a check, a read and compare per scanned entry, then per trial a setup
//   and a read and compare per compared pair, then the report; worst case quadratic in RING_DEPTH
// throughput: one transaction at a time; the result register lets the next
//   transaction in while the result waits
// reset: synchronous active-low rst_n clears control state, valid bits and
//   registers to their reset values; memories hold no reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "timestamp_stream_desync_finder_unit_assert.svh"

module timestamp_stream_desync_finder_unit #(
  parameter int RING_DEPTH  = 16,
  parameter int FRAME_WIDTH = 48
) (
  input  logic                          clk,
  input  logic                          rst_n,
  tsdf_in_if.sink                       in_chan,
  tsdf_out_if.source                    out_chan,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tsdf_pkg::CFG_AW-1:0]   paddr,
  input  logic [tsdf_pkg::CFG_W-1:0]    pwdata,
  output logic [tsdf_pkg::CFG_W-1:0]    prdata,
  output logic                          pready
);
  import tsdf_pkg::*;

  localparam int IW   = $clog2(RING_DEPTH);
  localparam int CW   = $clog2(RING_DEPTH + 1);
  localparam int SW   = CW + 1;
  localparam int CMPW = (FRAME_WIDTH > 32) ? FRAME_WIDTH : 32;
  localparam int DRW  = REL_W + FRAME_WIDTH;

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_P_PREP = 4'd1;
  localparam logic [3:0] S_P_RD   = 4'd2;
  localparam logic [3:0] S_P_OLD  = 4'd3;
  localparam logic [3:0] S_P_DIVR = 4'd4;
  localparam logic [3:0] S_P_DIVD = 4'd5;
  localparam logic [3:0] S_P_REL  = 4'd6;
  localparam logic [3:0] S_TGT_RD = 4'd7;
  localparam logic [3:0] S_TGT_WT = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;
  localparam logic [3:0] S_F_CHK  = 4'd10;
  localparam logic [3:0] S_F_SRD  = 4'd11;
  localparam logic [3:0] S_F_SCMP = 4'd12;
  localparam logic [3:0] S_F_TSET = 4'd13;
  localparam logic [3:0] S_F_TRD  = 4'd14;
  localparam logic [3:0] S_F_TCMP = 4'd15;

  // ring position plus offset, offset never above the depth
  function automatic logic [IW-1:0] ring_idx(input logic [IW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(off);
    if (s >= SW'(RING_DEPTH)) s = s - SW'(RING_DEPTH);
    return s[IW-1:0];
  endfunction

  // configuration registers
  logic [CFG_W-1:0] window_r, window_nxt;
  logic [CFG_W-1:0] ratio_r, ratio_nxt;
  logic [CFG_W-1:0] thresh_r, thresh_nxt;

  // control and ring state
  logic [3:0]             state_r, state_nxt;
  logic [TS_W-1:0]        ts_ref_r, ts_ref_nxt;
  logic [TS_W-1:0]        ts_dut_r, ts_dut_nxt;
  logic [TS_W-1:0]        tdr_r, tdr_nxt;
  logic [TS_W-1:0]        tdd_r, tdd_nxt;
  logic [TS_W-1:0]        prev_ref_r, prev_ref_nxt;
  logic [TS_W-1:0]        prev_dut_r, prev_dut_nxt;
  logic [FRAME_WIDTH-1:0] rf_r, rf_nxt;
  logic [FRAME_WIDTH-1:0] df_r, df_nxt;
  logic [IW-1:0]          wp_r, wp_nxt;
  logic                   empty_r, empty_nxt;
  logic                   wrapped_r, wrapped_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [RING_DEPTH-1:0]  vld_r, vld_nxt;

  // search state
  logic [IW-1:0] i_r, i_nxt;
  logic [IW-1:0] n_r, n_nxt;
  logic [IW-1:0] k_r, k_nxt;
  logic [CW-1:0] span_r, span_nxt;
  logic          sel_r, sel_nxt;
  logic [1:0]    bad_r, bad_nxt;

  // per-transaction results
  status_t        res_status_r, res_status_nxt;
  logic [IW-1:0]  res_desync_r, res_desync_nxt;
  logic [IW-1:0]  res_rs_r, res_rs_nxt;
  logic [IW-1:0]  res_ds_r, res_ds_nxt;
  logic [REL_W-1:0] tgt_r, tgt_nxt;

  // result register
  logic                 out_valid_r, out_valid_nxt;
  status_t              o_status_r, o_status_nxt;
  logic [CNT_OUT_W-1:0] o_count_r, o_count_nxt;
  logic                 o_full_r, o_full_nxt;
  logic [REL_W-1:0]     o_tgt_r, o_tgt_nxt;
  logic [IDX_OUT_W-1:0] o_desync_r, o_desync_nxt;
  logic [IDX_OUT_W-1:0] o_rs_r, o_rs_nxt;
  logic [IDX_OUT_W-1:0] o_ds_r, o_ds_nxt;

  // ring memories: reference frames, and relative difference with device frames
  logic [FRAME_WIDTH-1:0] ref_mem [RING_DEPTH];
  logic [DRW-1:0]         dr_mem  [RING_DEPTH];
  logic [FRAME_WIDTH-1:0] ref_q_r;
  logic [DRW-1:0]         dr_q_r;
  logic                   ref_vq_r, dr_vq_r;
  logic [IW-1:0]          ref_ra, dr_ra;
  logic                   mem_we;

  // arithmetic units
  sdiv_req_t              sd_req;
  logic                   sd_done;
  logic [FRAME_WIDTH-1:0] sd_q;
  logic                   rd_start;
  logic                   rd_done;
  logic [REL_W-1:0]       rd_q;

  // datapath helpers
  logic [CFG_W-1:0]       win;
  logic [FRAME_WIDTH-1:0] ref_eff, dut_eff, pair_diff;
  logic [REL_W-1:0]       rel_eff;
  logic                   rel_over, pair_over, new_over;
  logic [CW-1:0]          off_a, off_b, span_c, tests;
  logic [1:0]             bad_c;
  logic                   cfg_wr;
  logic                   accept;

  tsdf_scale_div #(.FRAME_WIDTH(FRAME_WIDTH)) u_sdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sd_req),
    .done  (sd_done),
    .quot  (sd_q)
  );

  tsdf_rel_div #(.FRAME_WIDTH(FRAME_WIDTH)) u_rdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (rd_start),
    .a     (rf_r),
    .b     (sd_q),
    .done  (rd_done),
    .quot  (rd_q)
  );

  // an entry never written since reset or clear reads as zero
  assign ref_eff   = ref_vq_r ? ref_q_r : '0;
  assign dut_eff   = dr_vq_r ? dr_q_r[FRAME_WIDTH-1:0] : '0;
  assign rel_eff   = dr_vq_r ? dr_q_r[DRW-1:FRAME_WIDTH] : '0;
  assign rel_over  = {16'd0, rel_eff} > thresh_r;
  assign new_over  = {16'd0, rd_q} > thresh_r;
  assign pair_diff = (ref_eff > dut_eff) ? (ref_eff - dut_eff) : (dut_eff - ref_eff);
  assign pair_over = CMPW'(pair_diff) > CMPW'(thresh_r);
  assign win       = (window_r == '0) ? 32'd1 : window_r;

  // search offsets: shifted stream at i+n+k, unshifted at i+k
  assign off_a  = CW'(i_r) + CW'(n_r) + CW'(k_r);
  assign off_b  = CW'(i_r) + CW'(k_r);
  assign span_c = CW'(RING_DEPTH) - CW'(i_r);
  assign tests  = span_r - CW'(n_r);
  assign bad_c  = bad_r + {1'b0, pair_over};

  assign accept = in_chan.valid && in_chan.ready;
  assign cfg_wr = psel && penable && pwrite;

  // read address selection
  always_comb begin
    ref_ra = sel_r ? ring_idx(wp_r, off_b) : ring_idx(wp_r, off_a);
    case (state_r)
      S_P_RD:  dr_ra = wp_r;
      S_F_SRD: dr_ra = ring_idx(wp_r, CW'(i_r) + CW'(1));
      S_F_TRD: dr_ra = sel_r ? ring_idx(wp_r, off_a) : ring_idx(wp_r, off_b);
      default: dr_ra = ring_idx(wp_r, CW'(1));
    endcase
  end

  // configuration writes, expected only while no transaction is in flight
  always_comb begin
    window_nxt = window_r;
    ratio_nxt  = ratio_r;
    thresh_nxt = thresh_r;
    if (cfg_wr) begin
      case (paddr[3:2])
        REG_WINDOW: window_nxt = pwdata;
        REG_RATIO:  ratio_nxt  = pwdata;
        REG_THRESH: thresh_nxt = pwdata;
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WINDOW: prdata = window_r;
      REG_RATIO:  prdata = ratio_r;
      REG_THRESH: prdata = thresh_r;
      default:    prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // main sequencer
  always_comb begin
    state_nxt      = state_r;
    ts_ref_nxt     = ts_ref_r;
    ts_dut_nxt     = ts_dut_r;
    tdr_nxt        = tdr_r;
    tdd_nxt        = tdd_r;
    prev_ref_nxt   = prev_ref_r;
    prev_dut_nxt   = prev_dut_r;
    rf_nxt         = rf_r;
    df_nxt         = df_r;
    wp_nxt         = wp_r;
    empty_nxt      = empty_r;
    wrapped_nxt    = wrapped_r;
    cnt_nxt        = cnt_r;
    vld_nxt        = vld_r;
    i_nxt          = i_r;
    n_nxt          = n_r;
    k_nxt          = k_r;
    span_nxt       = span_r;
    sel_nxt        = sel_r;
    bad_nxt        = bad_r;
    res_status_nxt = res_status_r;
    res_desync_nxt = res_desync_r;
    res_rs_nxt     = res_rs_r;
    res_ds_nxt     = res_ds_r;
    tgt_nxt        = tgt_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    o_status_nxt   = o_status_r;
    o_count_nxt    = o_count_r;
    o_full_nxt     = o_full_r;
    o_tgt_nxt      = o_tgt_r;
    o_desync_nxt   = o_desync_r;
    o_rs_nxt       = o_rs_r;
    o_ds_nxt       = o_ds_r;
    mem_we         = 1'b0;
    rd_start       = 1'b0;
    sd_req.start   = 1'b0;
    sd_req.num     = tdr_r;
    sd_req.mult    = REF_MULT;
    sd_req.den     = win;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          ts_ref_nxt     = in_chan.ref_timestamp;
          ts_dut_nxt     = in_chan.dut_timestamp;
          res_status_nxt = STAT_DONE;
          res_desync_nxt = '0;
          res_rs_nxt     = '0;
          res_ds_nxt     = '0;
          case (in_chan.operation)
            OP_PUSH: state_nxt = S_P_PREP;
            OP_CLEAR: begin
              // configuration registers survive; ring, count and previous timestamps back to reset
              vld_nxt      = '0;
              wp_nxt       = '0;
              empty_nxt    = 1'b1;
              wrapped_nxt  = 1'b0;
              cnt_nxt      = '0;
              prev_ref_nxt = '0;
              prev_dut_nxt = '0;
              state_nxt    = S_TGT_RD;
            end
            OP_FIND: state_nxt = S_F_CHK;
            default: state_nxt = S_TGT_RD;
          endcase
        end
      end

      // push: first pair after reset or clear gives zero differences in place
      S_P_PREP: begin
        if (empty_r) begin
          empty_nxt = 1'b0;
          tdr_nxt   = '0;
          tdd_nxt   = '0;
        end else begin
          tdr_nxt = ts_ref_r - prev_ref_r;
          tdd_nxt = ts_dut_r - prev_dut_r;
          wp_nxt  = ring_idx(wp_r, CW'(1));
          if (ring_idx(wp_r, CW'(1)) == '0) wrapped_nxt = 1'b1;
        end
        prev_ref_nxt = ts_ref_r;
        prev_dut_nxt = ts_dut_r;
        state_nxt    = S_P_RD;
      end
      S_P_RD: state_nxt = S_P_OLD;
      S_P_OLD: begin
        // retire the overwritten entry from the count
        if (rel_over && cnt_r != '0) cnt_nxt = cnt_r - 1'b1;
        sd_req.start = 1'b1;
        state_nxt    = S_P_DIVR;
      end
      S_P_DIVR: begin
        if (sd_done) begin
          rf_nxt       = sd_q;
          sd_req.start = 1'b1;
          sd_req.num   = tdd_r;
          sd_req.mult  = ratio_r;
          state_nxt    = S_P_DIVD;
        end
      end
      S_P_DIVD: begin
        if (sd_done) begin
          df_nxt    = sd_q;
          rd_start  = 1'b1;
          state_nxt = S_P_REL;
        end
      end
      S_P_REL: begin
        if (rd_done) begin
          mem_we        = 1'b1;
          vld_nxt[wp_r] = 1'b1;
          if (new_over && cnt_r < CW'(RING_DEPTH)) cnt_nxt = cnt_r + 1'b1;
          state_nxt = S_TGT_RD;
        end
      end

      // oldest entry is reported for every transaction
      S_TGT_RD: state_nxt = S_TGT_WT;
      S_TGT_WT: begin
        tgt_nxt   = rel_eff;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          o_status_nxt  = res_status_r;
          o_count_nxt   = CNT_OUT_W'(cnt_r);
          o_full_nxt    = wrapped_r;
          o_tgt_nxt     = tgt_r;
          o_desync_nxt  = IDX_OUT_W'(res_desync_r);
          o_rs_nxt      = IDX_OUT_W'(res_rs_r);
          o_ds_nxt      = IDX_OUT_W'(res_ds_r);
          state_nxt     = S_IDLE;
        end
      end

      // find: scan for first over-threshold entry from the oldest
      S_F_CHK: begin
        if (!wrapped_r) begin
          res_status_nxt = STAT_NOT_FULL;
          state_nxt      = S_TGT_RD;
        end else begin
          i_nxt     = '0;
          state_nxt = S_F_SRD;
        end
      end
      S_F_SRD: state_nxt = S_F_SCMP;
      S_F_SCMP: begin
        if (rel_over) begin
          res_desync_nxt = i_r;
          span_nxt       = span_c;
          if (span_c <= CW'(2)) begin
            res_status_nxt = STAT_TOO_SMALL;
            state_nxt      = S_TGT_RD;
          end else begin
            n_nxt     = IW'(1);
            sel_nxt   = 1'b0;
            state_nxt = S_F_TSET;
          end
        end else if (i_r == IW'(RING_DEPTH - 1)) begin
          res_status_nxt = STAT_IN_SYNC;
          state_nxt      = S_TGT_RD;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_F_SRD;
        end
      end

      // shift trial: reference shifted first, then the device stream
      S_F_TSET: begin
        k_nxt     = IW'(1);
        bad_nxt   = '0;
        state_nxt = S_F_TRD;
      end
      S_F_TRD: state_nxt = S_F_TCMP;
      S_F_TCMP: begin
        if (bad_c >= 2'd2) begin
          // trial lost, move to the next shift
          if (!sel_r) begin
            sel_nxt   = 1'b1;
            state_nxt = S_F_TSET;
          end else if (CW'(n_r) == span_r - CW'(2)) begin
            res_status_nxt = STAT_NONE;
            state_nxt      = S_TGT_RD;
          end else begin
            n_nxt     = n_r + 1'b1;
            sel_nxt   = 1'b0;
            state_nxt = S_F_TSET;
          end
        end else if (CW'(k_r) == tests) begin
          res_status_nxt = STAT_OFFSET;
          res_rs_nxt     = sel_r ? '0 : n_r;
          res_ds_nxt     = sel_r ? n_r : '0;
          state_nxt      = S_TGT_RD;
        end else begin
          k_nxt     = k_r + 1'b1;
          bad_nxt   = bad_c;
          state_nxt = S_F_TRD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_chan.ready = (state_r == S_IDLE);

  // ring memories, one write and one registered read each per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ref_mem[wp_r] <= rf_r;
      dr_mem[wp_r]  <= {rd_q, df_r};
    end
    ref_q_r  <= ref_mem[ref_ra];
    dr_q_r   <= dr_mem[dr_ra];
    ref_vq_r <= vld_r[ref_ra];
    dr_vq_r  <= vld_r[dr_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r     <= WINDOW_RST;
      ratio_r      <= RATIO_RST;
      thresh_r     <= THRESH_RST;
      state_r      <= S_IDLE;
      prev_ref_r   <= '0;
      prev_dut_r   <= '0;
      wp_r         <= '0;
      empty_r      <= 1'b1;
      wrapped_r    <= 1'b0;
      cnt_r        <= '0;
      vld_r        <= '0;
      out_valid_r  <= 1'b0;
      res_status_r <= STAT_DONE;
      res_desync_r <= '0;
      res_rs_r     <= '0;
      res_ds_r     <= '0;
    end else begin
      window_r     <= window_nxt;
      ratio_r      <= ratio_nxt;
      thresh_r     <= thresh_nxt;
      state_r      <= state_nxt;
      prev_ref_r   <= prev_ref_nxt;
      prev_dut_r   <= prev_dut_nxt;
      wp_r         <= wp_nxt;
      empty_r      <= empty_nxt;
      wrapped_r    <= wrapped_nxt;
      cnt_r        <= cnt_nxt;
      vld_r        <= vld_nxt;
      out_valid_r  <= out_valid_nxt;
      res_status_r <= res_status_nxt;
      res_desync_r <= res_desync_nxt;
      res_rs_r     <= res_rs_nxt;
      res_ds_r     <= res_ds_nxt;
    end
    ts_ref_r   <= ts_ref_nxt;
    ts_dut_r   <= ts_dut_nxt;
    tdr_r      <= tdr_nxt;
    tdd_r      <= tdd_nxt;
    rf_r       <= rf_nxt;
    df_r       <= df_nxt;
    i_r        <= i_nxt;
    n_r        <= n_nxt;
    k_r        <= k_nxt;
    span_r     <= span_nxt;
    sel_r      <= sel_nxt;
    bad_r      <= bad_nxt;
    tgt_r      <= tgt_nxt;
    o_status_r <= o_status_nxt;
    o_count_r  <= o_count_nxt;
    o_full_r   <= o_full_nxt;
    o_tgt_r    <= o_tgt_nxt;
    o_desync_r <= o_desync_nxt;
    o_rs_r     <= o_rs_nxt;
    o_ds_r     <= o_ds_nxt;
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.status          = o_status_r;
  assign out_chan.over_count      = o_count_r;
  assign out_chan.ring_full       = o_full_r;
  assign out_chan.target_rel_diff = o_tgt_r;
  assign out_chan.desync_distance = o_desync_r;
  assign out_chan.ref_shift       = o_rs_r;
  assign out_chan.dut_shift       = o_ds_r;

  // a wrapped ring has seen at least one push
  `TSDF_ASSERT_IMPLY(a_wrap_not_empty, clk, rst_n, wrapped_r, !empty_r)
  // the over-threshold count stays within the ring between transactions
  `TSDF_ASSERT_IMPLY(a_count_bound, clk, rst_n, state_r == S_IDLE, cnt_r <= CW'(RING_DEPTH))
  // every accepted transaction leaves idle
  `TSDF_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, state_r != S_IDLE)

endmodule
